>>> design/rrt_pkg.sv
package rrt_pkg;

  localparam int TableDepth = 64;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CountW     = $clog2(TableDepth + 1);
  localparam int MaxAlt     = 4;
  localparam int MsScaleW   = 20;
  localparam logic [MsScaleW-1:0] NsPerMs = MsScaleW'(1000000);

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_LOOKUP  = 3'd1;
  localparam logic [2:0] MODE_PROBE   = 3'd2;
  localparam logic [2:0] MODE_SUCCESS = 3'd3;
  localparam logic [2:0] MODE_FAILURE = 3'd4;
  localparam logic [2:0] MODE_EXPIRE  = 3'd5;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADHOP = 2'd1;
  localparam logic [1:0] STATUS_BETTER = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] dest_key;
    logic [31:0] latency;
    logic [31:0] ttl_ms;
    logic [7:0]  hops;
    logic [31:0] route_tag;
    logic [63:0] now_ns;
    logic [63:0] created_ns;
    logic [31:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] route_latency;
    logic [31:0] found_tag;
    logic [31:0] route_uses;
    logic [6:0]  entry_count;
    logic [31:0] discovered_total;
    logic [31:0] expired_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] failure_total;
    logic [63:0] byte_total;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] latency;
    logic [31:0] ttl;
    logic [63:0] created;
    logic [31:0] payload;
    logic [31:0] uses;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  idx;
    entry_t            e;
    logic              live;
  } live_t;

endpackage

>>> design/rrt_ram.sv
module rrt_ram
  import rrt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/rrt_live.sv
module rrt_live
  import rrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [AddrW-1:0] in_idx,
  input  entry_t           in_entry,
  input  logic [63:0]      now,
  output live_t            out
);

  logic             valid;
  logic [AddrW-1:0] idx;
  entry_t           e;
  logic [63:0]      diff;
  logic [63:0]      limit;

  // floor(diff / 1e6) <= ttl holds exactly when diff < (ttl + 1) * 1e6,
  // and that product stays below 2^53.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
    idx   <= in_idx;
    e     <= in_entry;
    diff  <= now - in_entry.created;
    limit <= ({32'd0, in_entry.ttl} + 64'd1) * 64'(NsPerMs);
  end

  assign out.valid = valid;
  assign out.idx   = idx;
  assign out.e     = e;
  assign out.live  = diff < limit;

endmodule

>>> design/relay_route_table.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | req_t, one command
// rsp     | out       | rsp_valid/rsp_stall | rsp_t, one result per command
// An item passes through accept, a scan of the held entries in the entry
// memory, finish and result; a zero-hop add or unknown mode skips scan and
// finish. An add on a full table or a failure report may add a second scan.
// Scans read the entries in turn through the entry memory's single read port.
// Reset is synchronous and clears the count and statistics; entry memory is
// not cleared. A result waits in the output register while the next word is
// taken; that word holds at its result step until the register is free.
module relay_route_table
  import rrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH, ST_DONE} state_t;
  typedef enum logic [2:0] {SK_SLOW, SK_BEST, SK_FIRST, SK_COMPACT, SK_SHIFT} kind_t;

  state_t            state;
  kind_t             kind;
  req_t              cmd;
  logic [CountW-1:0] held;
  logic [31:0]       disc, expc, hits, misses, fails;
  logic [63:0]       bsum;
  logic [CountW-1:0] issue_ptr, scan_end, w_ptr, match_cnt;
  logic              found;
  logic [AddrW-1:0]  sel_idx;
  entry_t            sel_e;
  logic [1:0]        status;
  logic              rv;
  logic [AddrW-1:0]  ridx;

  logic              issue;
  logic              we;
  logic [AddrW-1:0]  waddr;
  entry_t            wdata, rdata, new_e;
  live_t             lv;
  logic              match;
  logic              replace_ok;
  logic              report_hit;

  assign req_stall = (state != ST_IDLE);
  assign issue     = (state == ST_SCAN) && (issue_ptr < scan_end);
  assign match     = lv.e.key == cmd.dest_key;
  assign replace_ok = found && (sel_e.latency > cmd.latency);
  assign report_hit = (cmd.mode == MODE_LOOKUP || cmd.mode == MODE_PROBE) && found;

  assign new_e.key     = cmd.dest_key;
  assign new_e.latency = cmd.latency;
  assign new_e.ttl     = cmd.ttl_ms;
  assign new_e.created = cmd.created_ns;
  assign new_e.payload = cmd.route_tag;
  assign new_e.uses    = 32'd0;

  always_comb begin
    we    = 1'b0;
    waddr = lv.idx;
    wdata = lv.e;
    if (state == ST_SCAN && lv.valid) begin
      if (kind == SK_COMPACT && lv.live) begin
        we    = 1'b1;
        waddr = w_ptr[AddrW-1:0];
      end else if (kind == SK_SHIFT) begin
        we    = 1'b1;
        waddr = lv.idx - AddrW'(1);
      end
    end else if (state == ST_FINISH) begin
      case (cmd.mode)
        MODE_ADD: begin
          wdata = new_e;
          if (kind == SK_SLOW) begin
            if (match_cnt >= CountW'(MaxAlt)) begin
              we    = replace_ok;
              waddr = sel_idx;
            end else if (held < CountW'(TableDepth)) begin
              we    = 1'b1;
              waddr = held[AddrW-1:0];
            end
          end else if (w_ptr < CountW'(TableDepth)) begin
            we    = 1'b1;
            waddr = w_ptr[AddrW-1:0];
          end
        end
        MODE_SUCCESS: begin
          we         = found;
          waddr      = sel_idx;
          wdata      = sel_e;
          wdata.uses = sel_e.uses + 32'd1;
        end
        default: we = 1'b0;
      endcase
    end
  end

  rrt_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (issue_ptr[AddrW-1:0]),
    .rdata (rdata)
  );

  rrt_live u_live (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rv),
    .in_idx   (ridx),
    .in_entry (rdata),
    .now      (cmd.now_ns),
    .out      (lv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      disc      <= '0;
      expc      <= '0;
      hits      <= '0;
      misses    <= '0;
      fails     <= '0;
      bsum      <= '0;
      rv        <= 1'b0;
      rsp_valid <= 1'b0;
      issue_ptr <= '0;
      scan_end  <= '0;
    end else begin
      rv   <= issue;
      ridx <= issue_ptr[AddrW-1:0];
      if (issue) begin
        issue_ptr <= issue_ptr + CountW'(1);
      end
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cmd           <= req;
            found         <= 1'b0;
            match_cnt     <= '0;
            w_ptr         <= '0;
            sel_e.latency <= '0;
            issue_ptr     <= '0;
            scan_end      <= held;
            case (req.mode)
              MODE_ADD: begin
                kind <= SK_SLOW;
                if (req.hops == 8'd0) begin
                  status <= STATUS_BADHOP;
                  state  <= ST_DONE;
                end else begin
                  status <= STATUS_OK;
                  state  <= ST_SCAN;
                end
              end
              MODE_LOOKUP, MODE_PROBE: begin
                kind   <= SK_BEST;
                status <= STATUS_OK;
                state  <= ST_SCAN;
              end
              MODE_SUCCESS: begin
                kind   <= SK_FIRST;
                bsum   <= bsum + {32'd0, req.byte_count};
                status <= STATUS_OK;
                state  <= ST_SCAN;
              end
              MODE_FAILURE: begin
                kind   <= SK_SLOW;
                fails  <= fails + 32'd1;
                status <= STATUS_OK;
                state  <= ST_SCAN;
              end
              MODE_EXPIRE: begin
                kind   <= SK_COMPACT;
                status <= STATUS_OK;
                state  <= ST_SCAN;
              end
              default: begin
                status <= STATUS_OK;
                state  <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (lv.valid) begin
            case (kind)
              SK_SLOW: begin
                if (match) begin
                  match_cnt <= match_cnt + CountW'(1);
                  if (lv.e.latency > sel_e.latency) begin
                    sel_e   <= lv.e;
                    sel_idx <= lv.idx;
                    found   <= 1'b1;
                  end
                end
              end
              SK_BEST: begin
                if (match && lv.live && (!found || lv.e.latency < sel_e.latency)) begin
                  sel_e   <= lv.e;
                  sel_idx <= lv.idx;
                  found   <= 1'b1;
                end
              end
              SK_FIRST: begin
                if (match && !found) begin
                  sel_e   <= lv.e;
                  sel_idx <= lv.idx;
                  found   <= 1'b1;
                end
              end
              SK_COMPACT: begin
                if (lv.live) begin
                  w_ptr <= w_ptr + CountW'(1);
                end else begin
                  expc <= expc + 32'd1;
                end
              end
              default: ;
            endcase
          end else if (!issue && !rv) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          case (cmd.mode)
            MODE_ADD: begin
              if (kind == SK_SLOW) begin
                if (match_cnt >= CountW'(MaxAlt)) begin
                  state <= ST_DONE;
                  if (replace_ok) begin
                    disc <= disc + 32'd1;
                  end else begin
                    status <= STATUS_BETTER;
                  end
                end else if (held >= CountW'(TableDepth)) begin
                  // Table full: squeeze out expired routes, then retry.
                  kind      <= SK_COMPACT;
                  w_ptr     <= '0;
                  issue_ptr <= '0;
                  scan_end  <= held;
                  state     <= ST_SCAN;
                end else begin
                  held  <= held + CountW'(1);
                  disc  <= disc + 32'd1;
                  state <= ST_DONE;
                end
              end else begin
                state <= ST_DONE;
                if (w_ptr >= CountW'(TableDepth)) begin
                  held   <= w_ptr;
                  status <= STATUS_FULL;
                end else begin
                  held <= w_ptr + CountW'(1);
                  disc <= disc + 32'd1;
                end
              end
            end
            MODE_LOOKUP: begin
              state <= ST_DONE;
              if (found) begin
                hits <= hits + 32'd1;
              end else begin
                misses <= misses + 32'd1;
              end
            end
            MODE_FAILURE: begin
              if (kind == SK_SLOW && found) begin
                // Slide the routes after the removed one down by a slot.
                kind      <= SK_SHIFT;
                issue_ptr <= {1'b0, sel_idx} + CountW'(1);
                scan_end  <= held;
                state     <= ST_SCAN;
              end else begin
                state <= ST_DONE;
                if (kind != SK_SLOW) begin
                  held <= held - CountW'(1);
                end
              end
            end
            MODE_EXPIRE: begin
              held  <= w_ptr;
              state <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid            <= 1'b1;
            rsp.status           <= status;
            rsp.found            <= report_hit;
            rsp.route_latency    <= report_hit ? sel_e.latency : 32'd0;
            rsp.found_tag        <= report_hit ? sel_e.payload : 32'd0;
            rsp.route_uses       <= report_hit ? sel_e.uses : 32'd0;
            rsp.entry_count      <= held;
            rsp.discovered_total <= disc;
            rsp.expired_total    <= expc;
            rsp.hit_total        <= hits;
            rsp.miss_total       <= misses;
            rsp.failure_total    <= fails;
            rsp.byte_total       <= bsum;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CountW'(TableDepth))
    else $error("held count exceeds table depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    (rv || lv.valid) |-> state == ST_SCAN)
    else $error("scan pipeline active outside a scan");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> {1'b0, waddr} <= held)
    else $error("entry write beyond held routes");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && kind == SK_COMPACT && lv.valid) |-> w_ptr <= {1'b0, lv.idx})
    else $error("compaction write pointer passed the read pointer");

endmodule

>>> test/relay_route_table_test.sv
`timescale 1ns / 100ps

module relay_route_table_test
  import rrt_pkg::*;
();

  // Tracks the route table as the block should hold it and keeps the
  // results that accepted words are still owed.
  class route_scoreboard;
    bit [15:0] key_of [TableDepth];
    bit [31:0] lat_of [TableDepth];
    bit [31:0] ttl_of [TableDepth];
    bit [63:0] born_of [TableDepth];
    bit [31:0] tag_of [TableDepth];
    bit [31:0] uses_of [TableDepth];
    int        held;
    bit [31:0] discovered, expired, hits, misses, failures;
    bit [63:0] bytes;
    rsp_t      owed [$];
    int        errors;

    function bit is_live(int i, bit [63:0] now);
      bit [63:0] age;
      age = (now - born_of[i]) / 64'd1000000;
      return age <= {32'd0, ttl_of[i]};
    endfunction

    function void move_slot(int d, int s);
      key_of[d] = key_of[s];
      lat_of[d] = lat_of[s];
      ttl_of[d] = ttl_of[s];
      born_of[d] = born_of[s];
      tag_of[d] = tag_of[s];
      uses_of[d] = uses_of[s];
    endfunction

    function void sweep(bit [63:0] now);
      int w;
      w = 0;
      for (int i = 0; i < held; i++) begin
        if (is_live(i, now)) begin
          if (w != i) move_slot(w, i);
          w++;
        end else begin
          expired++;
        end
      end
      held = w;
    endfunction

    // Lowest slot holding the highest nonzero latency for the key; negative if none.
    function int slowest(bit [15:0] k, output int n);
      int idx;
      bit [31:0] worst;
      idx = -1;
      worst = 0;
      n = 0;
      for (int i = 0; i < held; i++) begin
        if (key_of[i] == k) begin
          n++;
          if (lat_of[i] > worst) begin
            worst = lat_of[i];
            idx = i;
          end
        end
      end
      return idx;
    endfunction

    function void store(int s, req_t r);
      key_of[s] = r.dest_key;
      lat_of[s] = r.latency;
      ttl_of[s] = r.ttl_ms;
      born_of[s] = r.created_ns;
      tag_of[s] = r.route_tag;
      uses_of[s] = 0;
    endfunction

    function bit [1:0] add_route(req_t r);
      int n, w;
      if (r.hops == 0) return STATUS_BADHOP;
      w = slowest(r.dest_key, n);
      if (n >= MaxAlt) begin
        if (w >= 0 && lat_of[w] > r.latency) begin
          store(w, r);
          discovered++;
          return STATUS_OK;
        end
        return STATUS_BETTER;
      end
      if (held >= TableDepth) begin
        sweep(r.now_ns);
        if (held >= TableDepth) return STATUS_FULL;
      end
      store(held, r);
      held++;
      discovered++;
      return STATUS_OK;
    endfunction

    function void note(req_t r);
      rsp_t e;
      int b, n;
      e = '0;
      if (r.mode == MODE_ADD) begin
        e.status = add_route(r);
      end else if (r.mode == MODE_LOOKUP || r.mode == MODE_PROBE) begin
        b = -1;
        for (int i = 0; i < held; i++)
          if (key_of[i] == r.dest_key && is_live(i, r.now_ns))
            if (b < 0 || lat_of[i] < lat_of[b]) b = i;
        if (b >= 0) begin
          e.found = 1'b1;
          e.route_latency = lat_of[b];
          e.found_tag = tag_of[b];
          e.route_uses = uses_of[b];
        end
        if (r.mode == MODE_LOOKUP) begin
          if (b >= 0) hits++;
          else misses++;
        end
      end else if (r.mode == MODE_SUCCESS) begin
        bytes += {32'd0, r.byte_count};
        for (int i = 0; i < held; i++)
          if (key_of[i] == r.dest_key) begin
            uses_of[i]++;
            break;
          end
      end else if (r.mode == MODE_FAILURE) begin
        failures++;
        b = slowest(r.dest_key, n);
        if (b >= 0) begin
          for (int i = b; i + 1 < held; i++) move_slot(i, i + 1);
          held--;
        end
      end else if (r.mode == MODE_EXPIRE) begin
        sweep(r.now_ns);
      end
      e.entry_count = held[6:0];
      e.discovered_total = discovered;
      e.expired_total = expired;
      e.hit_total = hits;
      e.miss_total = misses;
      e.failure_total = failures;
      e.byte_total = bytes;
      owed.push_back(e);
    endfunction

    function void report(string name, bit [63:0] want, bit [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check(rsp_t a);
      rsp_t e;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: %0h", a);
        errors++;
        return;
      end
      e = owed.pop_front();
      report("status", e.status, a.status);
      report("found", e.found, a.found);
      report("route_latency", e.route_latency, a.route_latency);
      report("found_tag", e.found_tag, a.found_tag);
      report("route_uses", e.route_uses, a.route_uses);
      report("entry_count", e.entry_count, a.entry_count);
      report("discovered_total", e.discovered_total, a.discovered_total);
      report("expired_total", e.expired_total, a.expired_total);
      report("hit_total", e.hit_total, a.hit_total);
      report("miss_total", e.miss_total, a.miss_total);
      report("failure_total", e.failure_total, a.failure_total);
      report("byte_total", e.byte_total, a.byte_total);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  route_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit [63:0] clock_ns;
  bit [15:0] key_pool [20];

  relay_route_table u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check(rsp);
  end

  task automatic send_word(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note(r);
    @(negedge clk);
  endtask

  function automatic req_t make_word(bit [2:0] m, bit [15:0] k, bit [31:0] lat,
                                     bit [31:0] ttl, bit [7:0] hops, bit [63:0] now,
                                     bit [63:0] born);
    req_t r;
    r.mode = m;
    r.dest_key = k;
    r.latency = lat;
    r.ttl_ms = ttl;
    r.hops = hops;
    r.route_tag = {$urandom};
    r.now_ns = now;
    r.created_ns = born;
    r.byte_count = {$urandom};
    return r;
  endfunction

  function automatic req_t random_word();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    clock_ns += 64'($urandom_range(4)) * 64'd1000000 + 64'($urandom_range(999999));
    r.mode = pick < 40 ? MODE_ADD : pick < 55 ? MODE_LOOKUP : pick < 65 ? MODE_PROBE :
             pick < 75 ? MODE_SUCCESS : pick < 85 ? MODE_FAILURE : pick < 95 ? MODE_EXPIRE :
             3'($urandom_range(7));
    r.dest_key = ($urandom_range(19) == 0) ? 16'($urandom) : key_pool[$urandom_range(19)];
    r.latency = ($urandom_range(9) == 0) ? {$urandom} : 32'($urandom_range(12));
    r.ttl_ms = ($urandom_range(9) == 0) ? {$urandom} :
               ($urandom_range(1) == 0) ? 32'($urandom_range(5)) : 32'($urandom_range(2000));
    r.hops = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom);
    r.route_tag = {$urandom};
    r.byte_count = {$urandom};
    r.now_ns = clock_ns;
    r.created_ns = clock_ns - 64'($urandom_range(3000000));
    // Occasional words with arbitrary times, most of which expire everything.
    if ($urandom_range(49) == 0) r.now_ns = {$urandom, $urandom};
    if ($urandom_range(49) == 0) r.created_ns = {$urandom, $urandom};
    return r;
  endfunction

  initial begin
    bit [63:0] far;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 6;
    recv_stall_pct = 73;
    clock_ns = 64'd5000000000;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hffff;
    for (int i = 2; i < 20; i++) key_pool[i] = 16'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    far = 64'hffff_ffff_ffff_ffff;
    send_word(make_word(MODE_ADD, 16'h0001, 32'd5, 32'd100, 8'd0, clock_ns, clock_ns));
    send_word(make_word(MODE_ADD, 16'h0001, 32'd5, 32'd100, 8'd1, clock_ns, clock_ns));
    send_word(make_word(MODE_ADD, 16'h0001, 32'd9, 32'd100, 8'd2, clock_ns, clock_ns));
    send_word(make_word(MODE_ADD, 16'h0001, 32'd9, 32'd100, 8'd3, clock_ns, clock_ns));
    send_word(make_word(MODE_ADD, 16'h0001, 32'd0, 32'd0, 8'hff, clock_ns, clock_ns));
    // Four alternatives held: a faster add replaces the first slowest one.
    send_word(make_word(MODE_ADD, 16'h0001, 32'd3, 32'd100, 8'd1, clock_ns, clock_ns));
    send_word(make_word(MODE_ADD, 16'h0001, 32'd20, 32'd100, 8'd1, clock_ns, clock_ns));
    for (int i = 0; i < 4; i++)
      send_word(make_word(MODE_ADD, 16'hffff, 32'd0, 32'hffffffff, 8'd1, far, far));
    send_word(make_word(MODE_ADD, 16'hffff, 32'hffffffff, 32'd1, 8'd1, far, far));
    send_word(make_word(MODE_LOOKUP, 16'h0001, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_PROBE, 16'hffff, 32'd0, 32'd0, 8'd0, far, 64'd0));
    send_word(make_word(MODE_LOOKUP, 16'h0002, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_SUCCESS, 16'h0001, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_SUCCESS, 16'h0002, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_LOOKUP, 16'h0001, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_FAILURE, 16'h0001, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_FAILURE, 16'hffff, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(MODE_FAILURE, 16'h0002, 32'd0, 32'd0, 8'd0, clock_ns, 64'd0));
    send_word(make_word(3'd6, 16'h0001, 32'd0, 32'd0, 8'd1, clock_ns, 64'd0));
    send_word(make_word(3'd7, 16'h0001, 32'd0, 32'd0, 8'd1, clock_ns, 64'd0));
    send_word(make_word(MODE_EXPIRE, 16'h0000, 32'd0, 32'd0, 8'd0,
                        clock_ns + 64'd200000000, 64'd0));

    // Hold the request side until the table has answered everything.
    req_valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);

    for (int n = 0; n < 1400; n++) begin
      if (n == 470) begin
        send_idle_pct = 73;
        recv_stall_pct = 6;
      end else if (n == 940) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_word(random_word());
    end
    req_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("relay_route_table_test OK");
    end else begin
      $display("relay_route_table_test NOT OK");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("relay_route_table_test NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
design/rrt_pkg.sv
design/rrt_ram.sv
design/rrt_live.sv
design/relay_route_table.sv
test/relay_route_table_test.sv
